// ===== rtl/core/pisw_pkg.sv =====
// Shared types, register indexes and saturation helper for the wrapped-error PID block.
package pisw_pkg;

   localparam int unsigned QSPAN_W = 13;
   localparam int unsigned LIMIT_W = 14;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned POS_W   = 15;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [IDX_W-1:0] REG_QSPAN      = 3'd3;
   localparam logic [IDX_W-1:0] REG_SEP_LIMIT  = 3'd4;

   localparam logic signed [49:0] I32_MAX_W = 50'sd2147483647;
   localparam logic signed [49:0] I32_MIN_W = -50'sd2147483648;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integral_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [QSPAN_W-1:0]       quarter_span;
      logic [LIMIT_W-1:0]       separation_limit;
   } cfg_type;

   // rem holds |difference| / 4 on entry and its remainder by quarter span on exit
   typedef struct packed {
      logic [QSPAN_W-1:0] rem;
      logic [1:0]         low;
      logic               neg;
      logic               fault;
   } div_item_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > I32_MAX_W) begin
         return 32'sh7fffffff;
      end else if (v < I32_MIN_W) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

// ===== rtl/core/pisw_div.sv =====
// Pipelined restoring remainder of a 13-bit value by the quarter span, one step per stage.
module pisw_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [12:0]           quarter_span,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pisw_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pisw_pkg::div_item_type out_item
);
   import pisw_pkg::*;

   localparam int unsigned STAGES = QSPAN_W;

   logic         valid_ff [STAGES];
   div_item_type item_ff  [STAGES];
   logic         rdy      [STAGES];

   genvar i;
   generate
      for (i = 0; i < STAGES; i++) begin : g_stage
         localparam int unsigned SHIFT = STAGES - 1 - i;
         logic         prev_valid;
         div_item_type prev_item;
         div_item_type item_in;
         logic         next_rdy;
         logic [24:0]  sub;

         if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_item  = in_item;
         end else begin : g_rest
            assign prev_valid = valid_ff[i-1];
            assign prev_item  = item_ff[i-1];
         end

         if (i == STAGES - 1) begin : g_last
            assign next_rdy = out_ready;
         end else begin : g_mid
            assign next_rdy = rdy[i+1];
         end

         assign rdy[i] = !valid_ff[i] || next_rdy;
         assign sub    = 25'(quarter_span) << SHIFT;

         always_comb begin
            item_in = prev_item;
            if (25'(prev_item.rem) >= sub) begin
               item_in.rem = prev_item.rem - sub[QSPAN_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (rdy[i]) begin
               valid_ff[i] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[i] && prev_valid) begin
               item_ff[i] <= item_in;
            end
         end
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = item_ff[STAGES-1];

endmodule

// ===== rtl/core/pisw_pid.sv =====
// Error fold, PID products with state update, and saturated output register.
module pisw_pid (
   input  logic                   clock,
   input  logic                   reset,
   input  pisw_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pisw_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [31:0]     out_drive,
   output logic signed [14:0]     out_folded_error,
   output logic                   out_excluded,
   output logic                   out_fault
);
   import pisw_pkg::*;

   // fold stage
   logic               f_valid_ff;
   logic signed [15:0] f_err_ff;
   logic               f_excl_ff;
   logic               f_fault_ff;
   logic signed [15:0] f_err_in;
   logic               f_excl_in;
   logic               f_ready;

   // product stage
   logic               a_valid_ff;
   logic signed [31:0] a_prop_ff;
   logic signed [32:0] a_deriv_ff;
   logic signed [47:0] a_integ_ff;
   logic signed [15:0] a_err_ff;
   logic               a_excl_ff;
   logic               a_fault_ff;
   logic               a_ready;

   // controller state
   logic signed [31:0] sum_ff;
   logic signed [31:0] sum_in;
   logic signed [15:0] prev_ff;
   logic signed [16:0] delta;

   // output stage
   logic               o_valid_ff;
   logic signed [31:0] o_drive_ff;
   logic signed [14:0] o_err_ff;
   logic               o_excl_ff;
   logic               o_fault_ff;
   logic               o_ready;
   logic signed [49:0] total;
   logic signed [49:0] shifted;

   logic [15:0] full16;
   logic [15:0] half16;
   logic [15:0] mod16;
   logic [15:0] pos16;
   logic [14:0] mag;

   assign o_ready  = !o_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || o_ready;
   assign f_ready  = !f_valid_ff || a_ready;
   assign in_ready = f_ready;

   // fold the remainder into the signed half-turn range
   always_comb begin
      full16 = {1'b0, cfg.quarter_span, 2'b00};
      half16 = {2'b00, cfg.quarter_span, 1'b0};
      mod16  = {1'b0, in_item.rem, in_item.low};
      pos16  = (in_item.neg && (mod16 != 16'd0)) ? full16 - mod16 : mod16;
      if (cfg.quarter_span == '0) begin
         f_err_in = '0;
      end else if (pos16 > half16) begin
         f_err_in = signed'(pos16 - full16);
      end else begin
         f_err_in = signed'(pos16);
      end
      mag       = f_err_in[15] ? 15'(-f_err_in) : f_err_in[14:0];
      f_excl_in = mag > {1'b0, cfg.separation_limit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_ready) begin
         f_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && in_valid) begin
         f_err_ff   <= f_err_in;
         f_excl_ff  <= f_excl_in;
         f_fault_ff <= in_item.fault;
      end
   end

   assign delta  = 17'(f_err_ff) - 17'(prev_ff);
   assign sum_in = sat32(50'(sum_ff) + 50'(f_err_ff));

   // products use the state from before this transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         sum_ff     <= '0;
         prev_ff    <= '0;
      end else if (a_ready) begin
         a_valid_ff <= f_valid_ff;
         if (f_valid_ff) begin
            sum_ff  <= sum_in;
            prev_ff <= f_err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && f_valid_ff) begin
         a_prop_ff  <= 32'(cfg.prop_gain) * 32'(f_err_ff);
         a_deriv_ff <= 33'(cfg.deriv_gain) * 33'(delta);
         a_integ_ff <= f_excl_ff ? 48'sd0 : 48'(cfg.integral_gain) * 48'(sum_ff);
         a_err_ff   <= f_err_ff;
         a_excl_ff  <= f_excl_ff;
         a_fault_ff <= f_fault_ff;
      end
   end

   assign total   = 50'(a_prop_ff) + 50'(a_deriv_ff) + 50'(a_integ_ff);
   assign shifted = total >>> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && a_valid_ff) begin
         o_drive_ff <= sat32(shifted);
         o_err_ff   <= a_err_ff[14:0];
         o_excl_ff  <= a_excl_ff;
         o_fault_ff <= a_fault_ff;
      end
   end

   assign out_valid        = o_valid_ff;
   assign out_drive        = o_drive_ff;
   assign out_folded_error = o_err_ff;
   assign out_excluded     = o_excl_ff;
   assign out_fault        = o_fault_ff;

endmodule

// ===== rtl/core/pid_integral_separation_wrap_core.sv =====
// Top level of the positional PID with integral separation on a circular position.
//
// Input channel req_*: one transaction per sample carries setpoint and measured.
// Result channel rsp_*: one transaction per sample carries drive, folded_error,
// integral_excluded and range_fault, in sample order.
// A transaction moves at a rising edge where valid is high and stall is low.
// The edge that accepts a sample loads the input register; the sample then moves
// through 13 remainder stages (one restoring step per stage for the 13-bit modulo
// by quarter span), then the fold, product/state and output stages, to rsp_*.
// Throughput is one sample per cycle while req_stall is low; every stage moves
// independently, so the pipeline keeps accepting while a result waits, until all
// stages are full.
// While rsp_stall is high the result holds; req_stall rises once no stage is free.
// Reset (synchronous, active high) empties the pipeline, clears the error sum
// and previous error, and loads the register defaults.
// csr_*: write registers 0..4 (prop, integral, derivative gain, quarter span,
// separation limit) only while the pipeline is empty.
module pid_integral_separation_wrap_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [14:0]        req_setpoint,
   input  logic [14:0]        req_measured,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   output logic signed [14:0] rsp_folded_error,
   output logic               rsp_integral_excluded,
   output logic               rsp_range_fault
);
   import pisw_pkg::*;

   cfg_type cfg_ff;

   logic              s0_valid_ff;
   logic [POS_W-1:0]  sp_ff;
   logic [POS_W-1:0]  me_ff;
   logic              s0_ready;

   logic [POS_W:0]    full16;
   logic signed [15:0] diff;
   logic [POS_W-1:0]  abs_diff;
   div_item_type      prep_item;

   logic              div_in_ready;
   logic              div_out_valid;
   div_item_type      div_out_item;
   logic              pid_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= 16'sd256;
         cfg_ff.integral_gain    <= 16'sd0;
         cfg_ff.deriv_gain       <= 16'sd0;
         cfg_ff.quarter_span     <= 13'd1024;
         cfg_ff.separation_limit <= 14'd100;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PROP_GAIN:  cfg_ff.prop_gain        <= signed'(csr_wdata);
            REG_INTEG_GAIN: cfg_ff.integral_gain    <= signed'(csr_wdata);
            REG_DERIV_GAIN: cfg_ff.deriv_gain       <= signed'(csr_wdata);
            REG_QSPAN:      cfg_ff.quarter_span     <= csr_wdata[QSPAN_W-1:0];
            REG_SEP_LIMIT:  cfg_ff.separation_limit <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign s0_ready  = !s0_valid_ff || div_in_ready;
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         sp_ff <= req_setpoint;
         me_ff <= req_measured;
      end
   end

   // split |difference| into its upper bits (|difference| / 4) and the two low bits
   always_comb begin
      full16          = {1'b0, cfg_ff.quarter_span, 2'b00};
      diff            = signed'({1'b0, sp_ff}) - signed'({1'b0, me_ff});
      abs_diff        = diff[15] ? 15'(-diff) : diff[14:0];
      prep_item.rem   = abs_diff[POS_W-1:2];
      prep_item.low   = abs_diff[1:0];
      prep_item.neg   = diff[15];
      prep_item.fault = ({1'b0, sp_ff} >= full16) || ({1'b0, me_ff} >= full16);
   end

   pisw_div u_div (
      .clock        (clock),
      .reset        (reset),
      .quarter_span (cfg_ff.quarter_span),
      .in_valid     (s0_valid_ff),
      .in_ready     (div_in_ready),
      .in_item      (prep_item),
      .out_valid    (div_out_valid),
      .out_ready    (pid_in_ready),
      .out_item     (div_out_item)
   );

   pisw_pid u_pid (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (div_out_valid),
      .in_ready         (pid_in_ready),
      .in_item          (div_out_item),
      .out_valid        (rsp_valid),
      .out_ready        (!rsp_stall),
      .out_drive        (rsp_drive),
      .out_folded_error (rsp_folded_error),
      .out_excluded     (rsp_integral_excluded),
      .out_fault        (rsp_range_fault)
   );

   // an empty output register frees every stage behind it
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while result register empty");

   // exclusion needs a nonzero error, since the limit is never negative
   a_excl_needs_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_integral_excluded) |-> (rsp_folded_error != 15'sd0))
      else $error("integral excluded with zero error");

   // the folded error lies above minus the half turn and at most the half turn, never the 15-bit minimum
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_folded_error != 15'sh4000))
      else $error("folded error out of range");

endmodule

// ===== dv/pid_integral_separation_wrap_core_tb.sv =====
// Self-checking testbench for the wrapped-error PID core with integral separation.
`timescale 1ns / 100ps

module pid_integral_separation_wrap_core_tb;
   import pisw_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned SAT_ITEMS = 1100;

   typedef struct packed {
      logic [POS_W-1:0] setpoint;
      logic [POS_W-1:0] measured;
   } sample_type;

   typedef struct packed {
      logic signed [31:0]      drive;
      logic signed [POS_W-1:0] folded_error;
      logic                    excluded;
      logic                    fault;
   } pid_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [14:0]        req_setpoint = '0;
   logic [14:0]        req_measured = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic signed [14:0] rsp_folded_error;
   logic               rsp_integral_excluded;
   logic               rsp_range_fault;

   pid_integral_separation_wrap_core DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_setpoint(req_setpoint),
      .req_measured(req_measured),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive),
      .rsp_folded_error(rsp_folded_error),
      .rsp_integral_excluded(rsp_integral_excluded),
      .rsp_range_fault(rsp_range_fault)
   );

   // controller image: register shadow and loop state
   cfg_type cfg_now;
   longint  err_sum_model = 0;
   longint  prev_err_model = 0;

   sample_type  sample_q[$];
   pid_out_type pid_expect_q[$];
   sample_type  next_sample;

   int unsigned total_queued = 0;
   int unsigned total_accepted = 0;
   int unsigned results_matched = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned settings_count = 0;
   int unsigned excluded_seen = 0;
   int unsigned fault_seen = 0;
   int unsigned sat_drive_seen = 0;

   bit          idle_on = 1'b0;
   bit          item_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_burst = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // advance the loop state by one sample and return the expected result
   function automatic pid_out_type pid_predict(sample_type s);
      pid_out_type r;
      longint sp, me, full, half, e, mag, total;
      bit fault, excl;
      sp = longint'(s.setpoint);
      me = longint'(s.measured);
      full = 4 * longint'(cfg_now.quarter_span);
      half = 2 * longint'(cfg_now.quarter_span);
      fault = (sp >= full) || (me >= full);
      e = 0;
      if (full > 0) begin
         e = (sp - me) % full;
         if (e < 0) e += full;
         if (e > half) e -= full;
      end
      mag = (e < 0) ? -e : e;
      excl = mag > longint'(cfg_now.separation_limit);
      total = longint'($signed(cfg_now.prop_gain)) * e
            + longint'($signed(cfg_now.deriv_gain)) * (e - prev_err_model);
      if (!excl) total += longint'($signed(cfg_now.integral_gain)) * err_sum_model;
      err_sum_model = clamp32(err_sum_model + e);
      prev_err_model = e;
      r.drive = 32'(clamp32(total >>> 8));
      r.folded_error = e[14:0];
      r.excluded = excl;
      r.fault = fault;
      return r;
   endfunction

   function automatic int wrap_into(int v, int full);
      return ((v % full) + full) % full;
   endfunction

   function automatic sample_type gen_sample();
      sample_type s;
      int full, half, lim, me, d;
      full = 4 * int'(cfg_now.quarter_span);
      half = 2 * int'(cfg_now.quarter_span);
      lim = int'(cfg_now.separation_limit);
      s.setpoint = 15'($urandom);
      s.measured = 15'($urandom);
      if (full == 0) return s;
      me = $urandom_range(0, full - 1);
      s.measured = 15'(me);
      case ($urandom_range(0, 9))
         0: ;  // raw 15-bit noise on the setpoint only
         1: begin
            s.setpoint = 15'((full + $urandom_range(0, 2) > 32767) ? 32767
                             : full + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 1)) s.measured = s.setpoint;
         end
         2: s.setpoint = 15'(me);
         3: s.setpoint = 15'(wrap_into(me + half - 1 + $urandom_range(0, 2), full));
         4: begin
            d = lim - 1 + $urandom_range(0, 2);
            if ($urandom_range(0, 1)) d = -d;
            s.setpoint = 15'(wrap_into(me + d, full));
         end
         default: s.setpoint = 15'($urandom_range(0, full - 1));
      endcase
      return s;
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_qspan();
      case ($urandom_range(0, 3))
         0: return 13'd1;
         1: return 13'd8191;
         2: return 13'($urandom_range(1, 64));
         default: return 13'($urandom_range(1, 8191));
      endcase
   endfunction

   function automatic logic [13:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 14'd0;
         1: return 14'd16383;
         2: return 14'($urandom_range(0, 200));
         default: return 14'($urandom_range(0, 16383));
      endcase
   endfunction

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_PROP_GAIN:  cfg_now.prop_gain = val;
         REG_INTEG_GAIN: cfg_now.integral_gain = val;
         REG_DERIV_GAIN: cfg_now.deriv_gain = val;
         REG_QSPAN:      cfg_now.quarter_span = val[QSPAN_W-1:0];
         REG_SEP_LIMIT:  cfg_now.separation_limit = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers are don't-care; fill them at random
   task automatic program_regs(logic [15:0] pg, logic [15:0] ig, logic [15:0] dg,
                               logic [12:0] qs, logic [13:0] lim);
      csr_write(REG_PROP_GAIN, pg);
      csr_write(REG_INTEG_GAIN, ig);
      csr_write(REG_DERIV_GAIN, dg);
      csr_write(REG_QSPAN, {3'($urandom), qs});
      csr_write(REG_SEP_LIMIT, {2'($urandom), lim});
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   task automatic queue_sample(int sp, int me);
      sample_type s;
      s.setpoint = 15'(sp);
      s.measured = 15'(me);
      sample_q.push_back(s);
      total_queued++;
   endtask

   task automatic queue_random(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         sample_q.push_back(gen_sample());
         total_queued++;
      end
   endtask

   task automatic start_phase(bit idle);
      @(posedge clock);
      idle_on = idle;
   endtask

   task automatic wait_idle();
      while (results_matched < total_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender: present the next sample once the current transaction has gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         item_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_q.size() > 0) begin
            next_sample = sample_q.pop_front();
            req_setpoint <= next_sample.setpoint;
            req_measured <= next_sample.measured;
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure: short random bursts plus the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (recv_burst > 0) recv_burst--;
         else if (idle_on && $urandom_range(0, 9) == 0) recv_burst = $urandom_range(1, 12);
         rsp_stall <= (recv_burst > 0) || (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
      end else if (hold_request) begin
         hold_left = 80;
         hold_request = 1'b0;
         holds_done++;
      end
   end

   // monitor: predict on input transactions, check on result transactions
   always @(posedge clock) begin
      pid_out_type got, want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            next_sample.setpoint = req_setpoint;
            next_sample.measured = req_measured;
            pid_expect_q.push_back(pid_predict({req_setpoint, req_measured}));
            item_taken = 1'b1;
            total_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.drive = rsp_drive;
            got.folded_error = rsp_folded_error;
            got.excluded = rsp_integral_excluded;
            got.fault = rsp_range_fault;
            if (pid_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result: drive %0d err %0d excl %0b fault %0b",
                           got.drive, got.folded_error, got.excluded, got.fault);
            end else begin
               want = pid_expect_q.pop_front();
               results_matched++;
               if (want.excluded) excluded_seen++;
               if (want.fault) fault_seen++;
               if (want.drive == 32'sh7fffffff || want.drive == 32'sh80000000) sat_drive_seen++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("ERROR: result %0d: drive exp %0d got %0d, err exp %0d got %0d",
                              results_matched, want.drive, got.drive, want.folded_error,
                              got.folded_error);
                     $display("       excl exp %0b got %0b, fault exp %0b got %0b",
                              want.excluded, got.excluded, want.fault, got.fault);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      cfg_now.prop_gain = 16'sd256;
      cfg_now.integral_gain = '0;
      cfg_now.deriv_gain = '0;
      cfg_now.quarter_span = 13'd1024;
      cfg_now.separation_limit = 14'd100;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: full turn 4096, half turn 2048, limit 100
      start_phase(1'b1);
      queue_sample(0, 0);
      queue_sample(32767, 0);
      queue_sample(0, 32767);
      queue_sample(4095, 4096);
      queue_sample(4095, 0);
      queue_sample(2048, 0);
      queue_sample(0, 2048);
      queue_sample(2049, 0);
      queue_sample(100, 0);
      queue_sample(0, 100);
      queue_sample(0, 101);
      queue_sample(3000, 3000);
      queue_sample(21845, 10922);
      queue_sample(10922, 21845);
      wait_idle();

      // smallest span, extreme gains, zero limit; a write to an unused index is ignored
      csr_write(REG_UNUSED, 16'hffff);
      program_regs(16'h8000, 16'h0001, 16'h7fff, 13'd1, 14'd0);
      start_phase(1'b1);
      queue_sample(0, 3);
      queue_sample(3, 0);
      queue_sample(2, 0);
      queue_sample(4, 0);
      queue_random(100);
      wait_idle();

      // zero quarter span: every input lies beyond the turn
      program_regs(pick_gain(), pick_gain(), pick_gain(), 13'd0, pick_limit());
      start_phase(1'b1);
      queue_sample(0, 0);
      queue_sample(32767, 32767);
      queue_random(60);
      wait_idle();

      // widest span with opposite extreme gains; hold the result side off meanwhile
      program_regs(16'h7fff, 16'h8000, 16'h8000, 13'd8191, 14'd16383);
      start_phase(1'b1);
      queue_sample(32763, 0);
      queue_sample(32764, 0);
      queue_sample(16382, 0);
      queue_sample(0, 16382);
      queue_sample(16383, 0);
      queue_random(120);
      hold_request = 1'b1;
      wait_idle();

      for (int p = 0; p < 3; p++) begin
         program_regs(pick_gain(), pick_gain(), pick_gain(), pick_qspan(), pick_limit());
         start_phase(p < 2);
         queue_random(150);
         wait_idle();
      end

      // grow the error sum until the drive saturates, integral always included
      program_regs(16'h0100, 16'h7fff, 16'h0000, 13'd8191, 14'd16383);
      start_phase(1'b0);
      for (int unsigned i = 0; i < SAT_ITEMS; i++) queue_sample(16382, 0);
      wait_idle();

      // flip the integral gain so the large sum drives the output negative
      program_regs(16'h7fff, 16'h8000, 16'h7fff, 13'd8191, 14'd16383);
      start_phase(1'b0);
      queue_random(12);
      wait_idle();

      repeat (40) @(posedge clock);
      if (pid_expect_q.size() != 0) begin
         mismatch_count++;
         $display("ERROR: %0d expected results never arrived", pid_expect_q.size());
      end
      $display("Run: %0d samples in, %0d results checked over %0d register settings, %0d holds.",
               total_accepted, results_matched, settings_count, holds_done);
      $display("Seen: %0d excluded-integral, %0d range-fault, %0d saturated-drive results.",
               excluded_seen, fault_seen, sat_drive_seen);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
